FILE: hw/rtl/normal_map_pixel_classifier_unit_macros.svh
//------------------------------------------------------------------------------
// Assertion macros for the normal map pixel classifier
// Short forms for the concurrent checks on the classifier's internal logic.
//------------------------------------------------------------------------------
`ifndef NORMAL_MAP_PIXEL_CLASSIFIER_UNIT_MACROS_SVH
`define NORMAL_MAP_PIXEL_CLASSIFIER_UNIT_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define NMPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define NMPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/nmpc_pkg.sv
//------------------------------------------------------------------------------
// Normal map pixel classifier package
// Fixed widths, test thresholds and the result type shared by the modules.
//------------------------------------------------------------------------------
package nmpc_pkg;

	localparam int unsigned COMP_W    = 9;
	localparam int unsigned SQ_W      = 16;
	localparam int unsigned CNT_OUT_W = 13;

	localparam int unsigned MIN_SAMPLES = 16;

	localparam int          Z_MIN   = 51;
	localparam int unsigned LEN2_LO = 57222;
	localparam int unsigned LEN2_HI = 72828;

	localparam int unsigned PCT_SCALE      = 100;
	localparam int unsigned NORMAL_PCT     = 95;
	localparam int unsigned MEAN_Z_SCALE   = 255;
	localparam int unsigned MEAN_MAG_SCALE = 25;
	localparam int unsigned MEAN_MAG_LIMIT = 765;
	localparam int unsigned VAR_SCALE      = 100;
	localparam int unsigned VAR_LIMIT      = 13005;

	typedef struct packed {
		logic                 is_normal;
		logic                 too_few;
		logic [CNT_OUT_W-1:0] sample_count;
		logic [CNT_OUT_W-1:0] normal_count;
	} result_t;

	// Maps an 8-bit code v to 2v - 255 in nine signed bits.
	function automatic logic signed [COMP_W-1:0] unpack(input logic [7:0] v);
		return $signed({~v[7], v[6:0], 1'b1});
	endfunction

endpackage

FILE: hw/rtl/nmpc_front.sv
//------------------------------------------------------------------------------
// Normal map pixel classifier front end
// Accepts pixels, squares the components and keeps the per-image accumulators.
//------------------------------------------------------------------------------
module nmpc_front #(
	parameter int unsigned MAX_SAMPLES = 4096,
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
	localparam int unsigned SW = CW + 9,
	localparam int unsigned QW = CW + 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic                 last,
	input  logic                 q_full,
	output logic                 snap_push,
	output logic [CW-1:0]        snap_n,
	output logic [CW-1:0]        snap_nc,
	output logic signed [SW-1:0] snap_sx,
	output logic signed [SW-1:0] snap_sy,
	output logic signed [SW-1:0] snap_sz,
	output logic [QW-1:0]        snap_q
);
	import nmpc_pkg::*;

	logic advance;
	logic accept;
	logic take;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nx;

	logic v_s1, v_s2, v_s3;
	logic take_s1, take_s2, take_s3;
	logic last_s1, last_s2, last_s3;
	logic [CW-1:0] cnt_s1, cnt_s2, cnt_s3;
	logic signed [COMP_W-1:0] cx_s1, cy_s1, cz_s1;
	logic signed [COMP_W-1:0] cx_s2, cy_s2, cz_s2;
	logic signed [COMP_W-1:0] cx_s3, cy_s3, cz_s3;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [SQ_W:0] xy2_s3;
	logic normal_s3;

	logic signed [2*COMP_W-1:0] px, py, pz;
	logic [SQ_W:0] xy2;
	logic [SQ_W+1:0] len2;
	logic normal;

	logic [CW-1:0] nc_q, nc_nx;
	logic signed [SW-1:0] sx_q, sy_q, sz_q, sx_nx, sy_nx, sz_nx;
	logic [QW-1:0] qs_q, qs_nx;

	assign advance     = !(v_s3 && last_s3 && q_full);
	assign pixel_stall = !advance;
	assign accept      = pixel_valid && advance;
	assign take        = cnt_q < CW'(MAX_SAMPLES);
	assign cnt_nx      = cnt_q + CW'(take);

	assign px = cx_s1 * cx_s1;
	assign py = cy_s1 * cy_s1;
	assign pz = cz_s1 * cz_s1;

	assign xy2    = (SQ_W+1)'(sqx_s2) + (SQ_W+1)'(sqy_s2);
	assign len2   = (SQ_W+2)'(xy2) + (SQ_W+2)'(sqz_s2);
	assign normal = (cz_s2 > $signed(COMP_W'(Z_MIN))) && (len2 > (SQ_W+2)'(LEN2_LO)) &&
		(len2 < (SQ_W+2)'(LEN2_HI));

	assign nc_nx = nc_q + CW'(take_s3 && normal_s3);
	assign sx_nx = take_s3 ? sx_q + SW'(cx_s3) : sx_q;
	assign sy_nx = take_s3 ? sy_q + SW'(cy_s3) : sy_q;
	assign sz_nx = take_s3 ? sz_q + SW'(cz_s3) : sz_q;
	assign qs_nx = take_s3 ? qs_q + QW'(xy2_s3) : qs_q;

	assign snap_push = advance && v_s3 && last_s3;
	assign snap_n    = cnt_s3;
	assign snap_nc   = nc_nx;
	assign snap_sx   = sx_nx;
	assign snap_sy   = sy_nx;
	assign snap_sz   = sz_nx;
	assign snap_q    = qs_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			nc_q  <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sz_q  <= '0;
			qs_q  <= '0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept) begin
				cnt_q <= last ? '0 : cnt_nx;
			end
			if (v_s3) begin
				if (last_s3) begin
					nc_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
					sz_q <= '0;
					qs_q <= '0;
				end else begin
					nc_q <= nc_nx;
					sx_q <= sx_nx;
					sy_q <= sy_nx;
					sz_q <= sz_nx;
					qs_q <= qs_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			take_s1 <= take;
			last_s1 <= last;
			cnt_s1  <= cnt_nx;
			cx_s1   <= unpack(red);
			cy_s1   <= unpack(green);
			cz_s1   <= unpack(blue);

			take_s2 <= take_s1;
			last_s2 <= last_s1;
			cnt_s2  <= cnt_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			cz_s2   <= cz_s1;
			sqx_s2  <= px[SQ_W-1:0];
			sqy_s2  <= py[SQ_W-1:0];
			sqz_s2  <= pz[SQ_W-1:0];

			take_s3   <= take_s2;
			last_s3   <= last_s2;
			cnt_s3    <= cnt_s2;
			cx_s3     <= cx_s2;
			cy_s3     <= cy_s2;
			cz_s3     <= cz_s2;
			xy2_s3    <= xy2;
			normal_s3 <= normal;
		end
	end

endmodule

FILE: hw/rtl/nmpc_queue.sv
//------------------------------------------------------------------------------
// Normal map pixel classifier image queue
// Two-entry queue of finished image totals between the front and back ends.
//------------------------------------------------------------------------------
module nmpc_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/nmpc_back.sv
//------------------------------------------------------------------------------
// Normal map pixel classifier back end
// Applies the image tests to one set of totals, with a shift-add variance unit.
//------------------------------------------------------------------------------
module nmpc_back #(
	parameter int unsigned MAX_SAMPLES = 4096,
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
	localparam int unsigned SW = CW + 9,
	localparam int unsigned QW = CW + 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic [CW-1:0]        q_n,
	input  logic [CW-1:0]        q_nc,
	input  logic signed [SW-1:0] q_sx,
	input  logic signed [SW-1:0] q_sy,
	input  logic signed [SW-1:0] q_sz,
	input  logic [QW-1:0]        q_qsum,
	input  logic                 result_stall,
	output logic                 result_valid,
	output nmpc_pkg::result_t    result
);
	import nmpc_pkg::*;

	localparam int unsigned MGW = CW + 8;
	localparam int unsigned LW  = 2 * CW + 24;
	localparam int unsigned SPW = $clog2(MGW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SUB1  = 3'd3;
	localparam logic [2:0] ST_SUB2  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [SPW-1:0] step_q;
	logic res_valid_q;
	result_t res_q;
	logic load;

	logic [CW-1:0] n_q, nc_q, mn_q;
	logic [MGW-1:0] ax_q, ay_q, mx_q, my_q;
	logic signed [SW-1:0] sz_q;
	logic [QW-1:0] qsum_q;
	logic few_q, pass_q;
	logic [LW-1:0] md_q, mxd_q, myd_q, mr_q;
	logic [LW-1:0] acc_l_q, acc_x_q, acc_y_q, acc_r_q;

	logic few, nc_ok, z_ok, x_ok, y_ok, pass;
	logic signed [SW+1:0] z_lhs, z_rhs;

	assign q_pop        = (state_q == ST_IDLE) && !q_empty;
	assign load         = (state_q == ST_DONE) && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign few   = n_q < CW'(MIN_SAMPLES);
	assign nc_ok = (CW+7)'(nc_q) * (CW+7)'(PCT_SCALE) >= (CW+7)'(n_q) * (CW+7)'(NORMAL_PCT);
	assign z_lhs = (SW+2)'(sz_q) <<< 1;
	assign z_rhs = $signed((SW+2)'(n_q) * (SW+2)'(MEAN_Z_SCALE));
	assign z_ok  = z_lhs > z_rhs;
	assign x_ok  = (MGW+5)'(ax_q) * (MGW+5)'(MEAN_MAG_SCALE) <
		(MGW+5)'(n_q) * (MGW+5)'(MEAN_MAG_LIMIT);
	assign y_ok  = (MGW+5)'(ay_q) * (MGW+5)'(MEAN_MAG_SCALE) <
		(MGW+5)'(n_q) * (MGW+5)'(MEAN_MAG_LIMIT);
	assign pass  = !few && nc_ok && z_ok && x_ok && y_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q  <= '0;
					state_q <= pass ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					step_q <= step_q + SPW'(1);
					if (step_q == SPW'(MGW - 1)) begin
						state_q <= ST_SUB1;
					end
				end
				ST_SUB1: begin
					state_q <= ST_SUB2;
				end
				ST_SUB2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					n_q    <= q_n;
					nc_q   <= q_nc;
					ax_q   <= MGW'(q_sx[SW-1] ? -q_sx : q_sx);
					ay_q   <= MGW'(q_sy[SW-1] ? -q_sy : q_sy);
					sz_q   <= q_sz;
					qsum_q <= q_qsum;
				end
			end
			ST_CHECK: begin
				few_q   <= few;
				pass_q  <= pass;
				mn_q    <= n_q;
				mx_q    <= ax_q;
				my_q    <= ay_q;
				md_q    <= LW'(qsum_q) * LW'(VAR_SCALE);
				mxd_q   <= LW'(ax_q) * LW'(VAR_SCALE);
				myd_q   <= LW'(ay_q) * LW'(VAR_SCALE);
				mr_q    <= LW'(n_q) * LW'(VAR_LIMIT);
				acc_l_q <= '0;
				acc_x_q <= '0;
				acc_y_q <= '0;
				acc_r_q <= '0;
			end
			ST_MUL: begin
				if (mn_q[0]) begin
					acc_l_q <= acc_l_q + md_q;
					acc_r_q <= acc_r_q + mr_q;
				end
				if (mx_q[0]) begin
					acc_x_q <= acc_x_q + mxd_q;
				end
				if (my_q[0]) begin
					acc_y_q <= acc_y_q + myd_q;
				end
				mn_q  <= mn_q >> 1;
				mx_q  <= mx_q >> 1;
				my_q  <= my_q >> 1;
				md_q  <= md_q << 1;
				mr_q  <= mr_q << 1;
				mxd_q <= mxd_q << 1;
				myd_q <= myd_q << 1;
			end
			ST_SUB1: begin
				acc_l_q <= acc_l_q - acc_x_q;
			end
			ST_SUB2: begin
				acc_l_q <= acc_l_q - acc_y_q;
			end
			ST_DONE: begin
				if (load) begin
					res_q.is_normal    <= pass_q && (acc_l_q > acc_r_q);
					res_q.too_few      <= few_q;
					res_q.sample_count <= CNT_OUT_W'(n_q);
					res_q.normal_count <= CNT_OUT_W'(nc_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/normal_map_pixel_classifier_unit.sv
//------------------------------------------------------------------------------
// Normal map pixel classifier
// Decides from sampled RGB8 pixels whether an image looks like a normal map.
//------------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  pixel     pixel_valid / pixel_stall   red, green, blue, last
//  result    result_valid / result_stall is_normal, too_few, sample_count,
//                                        normal_count
//
// Pixels pass a three-stage front pipeline, one per cycle unless stalled.
// When a simple test decides an image, its result skips the variance test;
// otherwise it waits for the variance test, which runs a shift-add unit one
// multiplier bit a cycle.
// Reset clears the pixel counter, the accumulators, the queue and result_valid.
// pixel_stall rises only while an image's last transaction waits at the end of
// the front pipeline for room in the two-entry image queue.
//------------------------------------------------------------------------------
`include "normal_map_pixel_classifier_unit_macros.svh"

module normal_map_pixel_classifier_unit #(
	parameter int unsigned MAX_SAMPLES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic                           last,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           is_normal,
	output logic                           too_few,
	output logic [nmpc_pkg::CNT_OUT_W-1:0] sample_count,
	output logic [nmpc_pkg::CNT_OUT_W-1:0] normal_count
);
	import nmpc_pkg::*;

	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SW = CW + 9;
	localparam int unsigned QW = CW + 17;
	localparam int unsigned EW = 2 * CW + 3 * SW + QW;

	logic q_push, q_full, q_pop, q_empty;
	logic [EW-1:0] q_wdata, q_rdata;
	logic [CW-1:0] snap_n, snap_nc, q_n, q_nc;
	logic signed [SW-1:0] snap_sx, snap_sy, snap_sz, q_sx, q_sy, q_sz;
	logic [QW-1:0] snap_q, q_qsum;
	result_t result;

	nmpc_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last       (last),
		.q_full     (q_full),
		.snap_push  (q_push),
		.snap_n     (snap_n),
		.snap_nc    (snap_nc),
		.snap_sx    (snap_sx),
		.snap_sy    (snap_sy),
		.snap_sz    (snap_sz),
		.snap_q     (snap_q)
	);

	assign q_wdata = {snap_n, snap_nc, snap_sx, snap_sy, snap_sz, snap_q};

	nmpc_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign {q_n, q_nc, q_sx, q_sy, q_sz, q_qsum} = q_rdata;

	nmpc_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_n         (q_n),
		.q_nc        (q_nc),
		.q_sx        (q_sx),
		.q_sy        (q_sy),
		.q_sz        (q_sz),
		.q_qsum      (q_qsum),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result      (result)
	);

	assign is_normal    = result.is_normal;
	assign too_few      = result.too_few;
	assign sample_count = result.sample_count;
	assign normal_count = result.normal_count;

	`NMPC_ASSERT_IMPLIES(a_push_has_room, clk, arst_n, q_push, !q_full, "image queue overflow")
	`NMPC_ASSERT_IMPLIES(a_pop_has_data, clk, arst_n, q_pop, !q_empty, "image queue underflow")
	`NMPC_ASSERT_IMPLIES(a_stall_on_full, clk, arst_n, pixel_stall, q_full, "stall without full queue")
	`NMPC_ASSERT_ALWAYS(a_few_not_normal, clk, arst_n, !(result_valid && too_few && is_normal),
		"short image classified as normal")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Normal map pixel classifier testbench
// Streams images of RGB8 samples into the classifier: a few hand-picked
// images, then random images of several shapes under changing idle and stall
// rates, and one long receiver hold-off. A scoreboard predicts each image's
// verdict and checks every result.
//------------------------------------------------------------------------------
module tb_top;

	localparam int MAX_PIXELS   = 4096;
	localparam int FEW_PIXELS   = 16;
	localparam int Z_FLOOR      = 51;
	localparam int LEN2_FLOOR   = 57222;
	localparam int LEN2_CEIL    = 72828;
	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int MIX_ITEMS    = 315;

	typedef enum int {
		STYLE_NOISE,
		STYLE_NORMAL,
		STYLE_TILTED,
		STYLE_FLAT
	} image_style_e;

	class verdict_book;
		longint             pixels_held;
		longint             normals_held;
		longint             sum_x;
		longint             sum_y;
		longint             sum_z;
		longint             sum_sq;
		nmpc_pkg::result_t  expected[$];
		int                 errors;

		function new();
			restart();
			errors = 0;
		endfunction

		function void restart();
			pixels_held  = 0;
			normals_held = 0;
			sum_x        = 0;
			sum_y        = 0;
			sum_z        = 0;
			sum_sq       = 0;
		endfunction

		function int signed_comp(logic [7:0] v);
			return int'(v) * 2 - 255;
		endfunction

		function bit looks_normal();
			longint n;
			longint ax;
			longint ay;
			longint spread;
			n = pixels_held;
			ax = (sum_x < 0) ? -sum_x : sum_x;
			ay = (sum_y < 0) ? -sum_y : sum_y;
			if (n < FEW_PIXELS)
				return 1'b0;
			if (normals_held * 100 < n * 95)
				return 1'b0;
			if (2 * sum_z <= 255 * n)
				return 1'b0;
			if (25 * ax >= 765 * n || 25 * ay >= 765 * n)
				return 1'b0;
			spread = n * sum_sq - sum_x * sum_x - sum_y * sum_y;
			return (100 * spread > 13005 * n * n);
		endfunction

		// Notes one accepted pixel transaction and queues a verdict on the last one.
		function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic l);
			int                cx;
			int                cy;
			int                cz;
			int                xy2;
			int                len2;
			nmpc_pkg::result_t v;
			if (pixels_held < MAX_PIXELS) begin
				cx = signed_comp(r);
				cy = signed_comp(g);
				cz = signed_comp(b);
				xy2 = cx * cx + cy * cy;
				len2 = xy2 + cz * cz;
				pixels_held++;
				if (cz > Z_FLOOR && len2 > LEN2_FLOOR && len2 < LEN2_CEIL)
					normals_held++;
				sum_x += cx;
				sum_y += cy;
				sum_z += cz;
				sum_sq += xy2;
			end
			if (l) begin
				v.is_normal = looks_normal();
				v.too_few = (pixels_held < FEW_PIXELS);
				v.sample_count = pixels_held[12:0];
				v.normal_count = normals_held[12:0];
				expected.insert(expected.size(), v);
				restart();
			end
		endfunction

		function void match_verdict(nmpc_pkg::result_t got);
			nmpc_pkg::result_t e;
			if (expected.size() == 0) begin
				$error("result transaction with no image pending");
				errors++;
				return;
			end
			e = expected.pop_front();
			if (got.is_normal !== e.is_normal) begin
				$error("is_normal: expected %0d, got %0d", e.is_normal, got.is_normal);
				errors++;
			end
			if (got.too_few !== e.too_few) begin
				$error("too_few: expected %0d, got %0d", e.too_few, got.too_few);
				errors++;
			end
			if (got.sample_count !== e.sample_count) begin
				$error("sample_count: expected %0d, got %0d", e.sample_count, got.sample_count);
				errors++;
			end
			if (got.normal_count !== e.normal_count) begin
				$error("normal_count: expected %0d, got %0d", e.normal_count, got.normal_count);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           pixel_valid;
	logic                           pixel_stall;
	logic [7:0]                     red;
	logic [7:0]                     green;
	logic [7:0]                     blue;
	logic                           last;
	logic                           result_valid;
	logic                           result_stall;
	logic                           is_normal;
	logic                           too_few;
	logic [nmpc_pkg::CNT_OUT_W-1:0] sample_count;
	logic [nmpc_pkg::CNT_OUT_W-1:0] normal_count;

	verdict_book tallies = new();
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          cycle_count = 0;

	normal_map_pixel_classifier_unit #(
		.MAX_SAMPLES(MAX_PIXELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.last(last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_normal(is_normal),
		.too_few(too_few),
		.sample_count(sample_count),
		.normal_count(normal_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tallies.match_verdict({is_normal, too_few, sample_count, normal_count});
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("normal_map_pixel_classifier_unit: mismatch");
		$finish;
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		last <= l;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		tallies.take_pixel(r, g, b, l);
		@(negedge clk);
	endtask

	task automatic send_image(input int len, input image_style_e style);
		int r;
		int g;
		int b;
		int shift_r;
		int shift_g;
		int flat_r;
		int flat_g;
		shift_r = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(5, 40));
		shift_g = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(5, 40));
		flat_r = $urandom_range(100, 155);
		flat_g = $urandom_range(100, 155);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(100, 155);
			g = $urandom_range(100, 155);
			b = ($urandom_range(11) == 0) ? $urandom_range(236, 254) : 255;
			case (style)
				STYLE_NOISE: begin
					r = $urandom_range(255);
					g = $urandom_range(255);
					b = $urandom_range(255);
				end
				STYLE_NORMAL: begin
					if ($urandom_range(39) == 0) begin
						r = $urandom_range(255);
						g = $urandom_range(255);
						b = $urandom_range(255);
					end
				end
				STYLE_TILTED: begin
					if ($urandom_range(1))
						r = r + shift_r;
					else
						g = g + shift_g;
				end
				STYLE_FLAT: begin
					r = flat_r;
					g = flat_g;
					b = 255;
				end
				default: ;
			endcase
			send_pixel(r[7:0], g[7:0], b[7:0], i == len - 1);
		end
	endtask

	task automatic run_mix(input int budget);
		int           used;
		int           pick;
		int           len;
		image_style_e style;
		used = 0;
		while (used < budget) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				len = $urandom_range(16, 48);
				style = STYLE_NORMAL;
			end else if (pick < 65) begin
				len = $urandom_range(1, 20);
				style = STYLE_NORMAL;
			end else if (pick < 78) begin
				len = $urandom_range(16, 40);
				style = STYLE_TILTED;
			end else if (pick < 86) begin
				len = $urandom_range(16, 30);
				style = STYLE_FLAT;
			end else begin
				len = $urandom_range(1, 30);
				style = STYLE_NOISE;
			end
			send_image(len, style);
			used += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		red = 8'd0;
		green = 8'd0;
		blue = 8'd0;
		last = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd0, 8'd255, 8'd128, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
		send_pixel(8'd128, 8'd127, 8'd255, 1'b1);
		send_image(16, STYLE_NORMAL);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			run_mix(MIX_ITEMS);
			if (p == 0) begin
				// The receiver holds off while short images keep coming, so the
				// image queue fills and the pixel input stalls.
				hold_req = 1'b1;
				for (int k = 0; k < 10; k++)
					send_image(2, STYLE_NOISE);
			end
		end

		pixel_valid <= 1'b0;
		while (tallies.expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tallies.errors == 0 && tallies.expected.size() == 0)
			$display("normal_map_pixel_classifier_unit: match");
		else
			$display("normal_map_pixel_classifier_unit: mismatch");
		$finish;
	end

endmodule

FILE: normal_map_pixel_classifier_unit.f
+incdir+hw/rtl
hw/rtl/nmpc_pkg.sv
hw/rtl/nmpc_front.sv
hw/rtl/nmpc_queue.sv
hw/rtl/nmpc_back.sv
hw/rtl/normal_map_pixel_classifier_unit.sv
tb/tb_top.sv
